@@ rtl/core/wemt_pkg.sv @@
// Package for the windowed edge magnitude tracker.
// Holds field widths, register defaults, register indexes and shared types.
// No dependencies.
package wemt_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int EDGE_W     = 16;
	localparam int POS_W      = 16;
	localparam int HW_W       = 6;
	localparam int LEN_W      = 16;
	localparam int SCALE_W    = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam int MAX_WINDOW_DEF  = 32;
	localparam int MAX_SAMPLES_DEF = 65536;

	localparam logic [HW_W-1:0]    HW_RESET       = 6'd4;
	localparam logic [LEN_W-1:0]   TICK_LEN_RESET = 16'd64;
	localparam logic [LEN_W-1:0]   FULL_LEN_RESET = 16'd3840;
	localparam logic [SCALE_W-1:0] SCALE_RESET    = 16'd1434;

	// floor(v / 3) == (v * DIV3_RECIP) >> DIV3_SHIFT for any 16-bit v
	localparam logic [16:0] DIV3_RECIP = 17'd43691;
	localparam int          DIV3_SHIFT = 17;

	// Q4.12 scale: round half up, then drop the fraction
	localparam logic [32:0] THR_ROUND = 33'd2048;
	localparam int          THR_SHIFT = 12;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_HALF_WINDOW = 2'd0,
		CFG_TICK_LEN    = 2'd1,
		CFG_FULL_LEN    = 2'd2,
		CFG_THR_SCALE   = 2'd3
	} cfg_reg_t;

	// Result of the end-of-recording view computation
	typedef struct packed {
		logic              valid;
		logic [EDGE_W-1:0] auto_threshold;
		logic [POS_W-1:0]  tick_view_start;
		logic [POS_W-1:0]  full_view_start;
	} view_res_t;

endpackage

@@ rtl/core/wemt_if.sv @@
// Channel interfaces of the windowed edge magnitude tracker.
// Sample input, edge result output and configuration write channel.
// Depends on wemt_pkg.
interface wemt_in_if;
	import wemt_pkg::*;
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       is_final;
	modport source (output valid, output sample, output is_final, input ready);
	modport sink (input valid, input sample, input is_final, output ready);
endinterface

interface wemt_out_if;
	import wemt_pkg::*;
	logic              valid;
	logic              ready;
	logic [EDGE_W-1:0] edge_value;
	logic [POS_W-1:0]  edge_position;
	logic              last_of_run;
	logic [EDGE_W-1:0] peak_edge;
	logic [POS_W-1:0]  peak_edge_index;
	logic [EDGE_W-1:0] raw_peak;
	logic [EDGE_W-1:0] auto_threshold;
	logic [POS_W-1:0]  tick_view_start;
	logic [POS_W-1:0]  full_view_start;
	modport source (output valid, output edge_value, output edge_position, output last_of_run,
		output peak_edge, output peak_edge_index, output raw_peak, output auto_threshold,
		output tick_view_start, output full_view_start, input ready);
	modport sink (input valid, input edge_value, input edge_position, input last_of_run,
		input peak_edge, input peak_edge_index, input raw_peak, input auto_threshold,
		input tick_view_start, input full_view_start, output ready);
endinterface

interface wemt_cfg_if;
	import wemt_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  idx;
	logic [CFG_DATA_W-1:0] wdata;
	modport source (output valid, output idx, output wdata, input ready);
	modport sink (input valid, input idx, input wdata, output ready);
endinterface

@@ rtl/core/wemt_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// Read data holds while no read is issued. No dependencies.
module wemt_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

@@ rtl/core/wemt_view.sv @@
// End-of-recording computation: auto threshold and clamped view starts.
// Three register stages after start; result holds until the next start.
// Depends on wemt_pkg.
module wemt_view #(
	parameter int IW   = 16,
	parameter int CNTW = 17
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [wemt_pkg::EDGE_W-1:0]   best_edge,
	input  logic [IW-1:0]                 best_index,
	input  logic [CNTW-1:0]               sample_count,
	input  logic [wemt_pkg::LEN_W-1:0]    tick_len,
	input  logic [wemt_pkg::LEN_W-1:0]    full_len,
	input  logic [wemt_pkg::SCALE_W-1:0]  scale,
	output wemt_pkg::view_res_t           res
);
	import wemt_pkg::*;

	localparam int VW = ((CNTW > LEN_W) ? CNTW : LEN_W) + 1;

	logic        go_s1, go_s2;
	logic [31:0] thr_prod_s1;
	logic [32:0] tick_prod_s1;
	logic [EDGE_W-1:0] thr_s2;
	logic [VW-1:0] tick_s0_s2, full_s0_s2;
	logic              res_valid_q;
	logic [EDGE_W-1:0] thr_s3;
	logic [POS_W-1:0]  tick_st_s3, full_st_s3;

	logic [32:0]      thr_sum, thr_shr;
	logic [EDGE_W-1:0] thr_sat;
	logic [LEN_W-1:0] tick_back, full_back;
	logic [VW-1:0]    bi, tick_s0, full_s0;
	logic [VW-1:0]    cnt, tick_end, full_end, tick_st, full_st;

	always_comb begin
		thr_sum   = {1'b0, thr_prod_s1} + THR_ROUND;
		thr_shr   = thr_sum >> THR_SHIFT;
		thr_sat   = (thr_shr > 33'h0_0000_FFFF) ? 16'hFFFF : thr_shr[15:0];
		tick_back = 16'(tick_prod_s1 >> DIV3_SHIFT);
		full_back = full_len >> 1;
		bi        = VW'(best_index);
		tick_s0   = (bi >= VW'(tick_back)) ? bi - VW'(tick_back) : '0;
		full_s0   = (bi >= VW'(full_back)) ? bi - VW'(full_back) : '0;

		// pull the view back inside the recording, or to 0 if it is longer
		cnt      = VW'(sample_count);
		tick_end = tick_s0_s2 + VW'(tick_len);
		full_end = full_s0_s2 + VW'(full_len);
		tick_st  = tick_s0_s2;
		if (tick_end > cnt) begin
			tick_st = (cnt >= VW'(tick_len)) ? cnt - VW'(tick_len) : '0;
		end
		full_st = full_s0_s2;
		if (full_end > cnt) begin
			full_st = (cnt >= VW'(full_len)) ? cnt - VW'(full_len) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			go_s1       <= 1'b0;
			go_s2       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			go_s1 <= start;
			go_s2 <= go_s1;
			if (start) begin
				res_valid_q <= 1'b0;
			end else if (go_s2) begin
				res_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			thr_prod_s1  <= 32'(best_edge) * 32'(scale);
			tick_prod_s1 <= 33'(tick_len) * 33'(DIV3_RECIP);
		end
		if (go_s1) begin
			thr_s2     <= thr_sat;
			tick_s0_s2 <= tick_s0;
			full_s0_s2 <= full_s0;
		end
		if (go_s2) begin
			thr_s3     <= thr_s2;
			tick_st_s3 <= 16'(tick_st);
			full_st_s3 <= 16'(full_st);
		end
	end

	assign res = '{valid: res_valid_q, auto_threshold: thr_s3,
		tick_view_start: tick_st_s3, full_view_start: full_st_s3};
endmodule

@@ rtl/core/windowed_edge_magnitude_tracker.sv @@
// Each item sweeps its n pending entries (n <= MAX_WINDOW), one entry a cycle unless
// output backpressure stalls an emit; entries past the window are emitted, the rest get
// a RAM read-modify-write. The final item of a recording also waits for the threshold and
// view unit. A new item waits until the last is done; results stall on backpressure.
// Reset: registers take their defaults and the queue is empty; RAM contents are
// not cleared, the fill count guards them. Depends on wemt_pkg, wemt_if, wemt_ram, wemt_view.
module windowed_edge_magnitude_tracker #(
	parameter int MAX_WINDOW  = wemt_pkg::MAX_WINDOW_DEF,
	parameter int MAX_SAMPLES = wemt_pkg::MAX_SAMPLES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	wemt_in_if.sink      samples,
	wemt_out_if.source   edges,
	wemt_cfg_if.sink     cfg
);
	import wemt_pkg::*;

	localparam int AW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int CW   = $clog2(MAX_WINDOW + 1);
	localparam int IW   = $clog2(MAX_SAMPLES);
	localparam int CNTW = $clog2(MAX_SAMPLES + 1);

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] smp;
		logic [EDGE_W-1:0]          emax;
		logic [IW-1:0]              pos;
	} entry_t;

	localparam int MW = $bits(entry_t);

	typedef enum logic [1:0] {ST_IDLE, ST_SWEEP, ST_APPEND, ST_FINAL} state_t;

	function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
		return (p == AW'(MAX_WINDOW - 1)) ? '0 : p + 1'b1;
	endfunction

	state_t state_q;
	logic [HW_W-1:0]    half_window_q;
	logic [LEN_W-1:0]   tick_len_q, full_len_q;
	logic [SCALE_W-1:0] scale_q;

	logic signed [SAMPLE_W-1:0] x_q;
	logic          fin_q, new_emit_q;
	logic [IW-1:0] idx_q;
	logic [AW-1:0] head_q, tail_q, sp_q;
	logic [CW-1:0] count_q, n_q, k_q, e_q;
	logic [CNTW-1:0]   sample_cnt_q;
	logic [EDGE_W-1:0] best_edge_q, peak_q;
	logic [IW-1:0]     best_idx_q;

	logic              out_valid_q, out_last_q;
	logic [EDGE_W-1:0] out_edge_q, out_peak_edge_q, out_raw_q, out_thr_q;
	logic [POS_W-1:0]  out_pos_q, out_peak_idx_q, out_tick_q, out_full_q;

	logic [6:0]    hw_ext;
	logic [CW-1:0] hw_c, e_new;
	logic [CW:0]   cnt_inc, e_diff, k_inc;
	logic          in_fire, slot_free, emitting, sweep_go, more, out_load;
	logic signed [SAMPLE_W:0] x_ext, x_abs17, diff, diff_abs;
	logic [EDGE_W-1:0] x_abs, new_max;
	logic [IW-1:0]     idx_next;
	entry_t            rd_entry, wr_entry;
	logic [MW-1:0]     ram_rdata;
	logic              ram_we, ram_re, view_start;
	logic [AW-1:0]     ram_waddr, ram_raddr;
	view_res_t         view_res;

	assign samples.ready = (state_q == ST_IDLE);
	assign cfg.ready     = 1'b1;
	assign in_fire       = samples.valid && samples.ready;
	assign slot_free     = !out_valid_q || edges.ready;

	always_comb begin
		hw_ext = {1'b0, half_window_q};
		hw_c   = (hw_ext > 7'(MAX_WINDOW)) ? CW'(MAX_WINDOW) : CW'(hw_ext);

		x_ext   = {samples.sample[SAMPLE_W-1], samples.sample};
		x_abs17 = (x_ext < 0) ? -x_ext : x_ext;
		x_abs   = x_abs17[EDGE_W-1:0];

		// entries past the window once the new sample is queued; a final sample flushes all
		cnt_inc = {1'b0, count_q} + 1'b1;
		e_diff  = cnt_inc - {1'b0, hw_c};
		if (samples.is_final) begin
			e_new = count_q;
		end else if (cnt_inc > {1'b0, hw_c}) begin
			e_new = (e_diff > {1'b0, count_q}) ? count_q : e_diff[CW-1:0];
		end else begin
			e_new = '0;
		end

		idx_next = (sample_cnt_q < CNTW'(MAX_SAMPLES)) ? IW'(sample_cnt_q)
			: IW'(MAX_SAMPLES - 1);

		rd_entry = entry_t'(ram_rdata);
		diff     = {rd_entry.smp[SAMPLE_W-1], rd_entry.smp} - {x_q[SAMPLE_W-1], x_q};
		diff_abs = (diff < 0) ? -diff : diff;
		new_max  = (diff_abs[EDGE_W-1:0] > rd_entry.emax) ? diff_abs[EDGE_W-1:0]
			: rd_entry.emax;

		emitting = (k_q < e_q);
		sweep_go = (state_q == ST_SWEEP) && (!emitting || slot_free);
		k_inc    = {1'b0, k_q} + 1'b1;
		more     = (k_inc < {1'b0, n_q});

		ram_re    = (in_fire && count_q != '0) || (sweep_go && more);
		ram_raddr = (state_q == ST_IDLE) ? head_q : wrap_inc(sp_q);
		ram_we    = (sweep_go && !emitting) || (state_q == ST_APPEND && !new_emit_q);
		ram_waddr = (state_q == ST_SWEEP) ? sp_q : tail_q;
		if (state_q == ST_SWEEP) begin
			wr_entry = '{smp: rd_entry.smp, emax: new_max, pos: rd_entry.pos};
		end else begin
			wr_entry = '{smp: x_q, emax: '0, pos: idx_q};
		end

		view_start = (state_q == ST_APPEND) && new_emit_q && fin_q;

		// a new item goes into the output register this cycle
		out_load = (sweep_go && emitting)
			|| (state_q == ST_APPEND && new_emit_q && !fin_q && slot_free)
			|| (state_q == ST_FINAL && view_res.valid && slot_free);
	end

	wemt_ram #(
		.WIDTH(MW),
		.DEPTH(MAX_WINDOW)
	) u_queue (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (wr_entry),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	wemt_view #(
		.IW   (IW),
		.CNTW (CNTW)
	) u_view (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (view_start),
		.best_edge    (best_edge_q),
		.best_index   (best_idx_q),
		.sample_count (sample_cnt_q),
		.tick_len     (tick_len_q),
		.full_len     (full_len_q),
		.scale        (scale_q),
		.res          (view_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			half_window_q   <= HW_RESET;
			tick_len_q      <= TICK_LEN_RESET;
			full_len_q      <= FULL_LEN_RESET;
			scale_q         <= SCALE_RESET;
			head_q          <= '0;
			tail_q          <= '0;
			count_q         <= '0;
			sample_cnt_q    <= '0;
			best_edge_q     <= '0;
			best_idx_q      <= '0;
			peak_q          <= '0;
			x_q             <= '0;
			fin_q           <= 1'b0;
			idx_q           <= '0;
			new_emit_q      <= 1'b0;
			e_q             <= '0;
			n_q             <= '0;
			k_q             <= '0;
			sp_q            <= '0;
			out_valid_q     <= 1'b0;
			out_edge_q      <= '0;
			out_pos_q       <= '0;
			out_last_q      <= 1'b0;
			out_peak_edge_q <= '0;
			out_peak_idx_q  <= '0;
			out_raw_q       <= '0;
			out_thr_q       <= '0;
			out_tick_q      <= '0;
			out_full_q      <= '0;
		end else begin
			if (cfg.valid) begin
				case (cfg_reg_t'(cfg.idx))
					CFG_HALF_WINDOW: half_window_q <= cfg.wdata[HW_W-1:0];
					CFG_TICK_LEN:    tick_len_q    <= cfg.wdata;
					CFG_FULL_LEN:    full_len_q    <= cfg.wdata;
					CFG_THR_SCALE:   scale_q       <= cfg.wdata;
					default: ;
				endcase
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (edges.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						x_q        <= samples.sample;
						fin_q      <= samples.is_final;
						idx_q      <= idx_next;
						new_emit_q <= samples.is_final || (hw_c == '0);
						e_q        <= e_new;
						n_q        <= count_q;
						k_q        <= '0;
						sp_q       <= head_q;
						if (sample_cnt_q < CNTW'(MAX_SAMPLES)) begin
							sample_cnt_q <= sample_cnt_q + 1'b1;
						end
						if (x_abs > peak_q) begin
							peak_q <= x_abs;
						end
						state_q <= (count_q != '0) ? ST_SWEEP : ST_APPEND;
					end
				end
				ST_SWEEP: begin
					if (sweep_go) begin
						if (emitting) begin
							out_edge_q      <= new_max;
							out_pos_q       <= POS_W'(rd_entry.pos);
							out_last_q      <= 1'b0;
							out_peak_edge_q <= '0;
							out_peak_idx_q  <= '0;
							out_raw_q       <= '0;
							out_thr_q       <= '0;
							out_tick_q      <= '0;
							out_full_q      <= '0;
							if (new_max > best_edge_q) begin
								best_edge_q <= new_max;
								best_idx_q  <= rd_entry.pos;
							end
							head_q  <= wrap_inc(head_q);
							count_q <= count_q - 1'b1;
						end
						k_q  <= k_inc[CW-1:0];
						sp_q <= wrap_inc(sp_q);
						if (!more) begin
							state_q <= ST_APPEND;
						end
					end
				end
				ST_APPEND: begin
					if (new_emit_q) begin
						if (fin_q) begin
							state_q <= ST_FINAL;
						end else if (slot_free) begin
							// zero window: the new sample leaves at once with edge 0
							out_edge_q      <= '0;
							out_pos_q       <= POS_W'(idx_q);
							out_last_q      <= 1'b0;
							out_peak_edge_q <= '0;
							out_peak_idx_q  <= '0;
							out_raw_q       <= '0;
							out_thr_q       <= '0;
							out_tick_q      <= '0;
							out_full_q      <= '0;
							state_q         <= ST_IDLE;
						end
					end else begin
						tail_q  <= wrap_inc(tail_q);
						count_q <= count_q + 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_FINAL: begin
					if (view_res.valid && slot_free) begin
						out_edge_q      <= '0;
						out_pos_q       <= POS_W'(idx_q);
						out_last_q      <= 1'b1;
						out_peak_edge_q <= best_edge_q;
						out_peak_idx_q  <= POS_W'(best_idx_q);
						out_raw_q       <= peak_q;
						out_thr_q       <= view_res.auto_threshold;
						out_tick_q      <= view_res.tick_view_start;
						out_full_q      <= view_res.full_view_start;
						// start a new recording
						head_q       <= '0;
						tail_q       <= '0;
						count_q      <= '0;
						sample_cnt_q <= '0;
						best_edge_q  <= '0;
						best_idx_q   <= '0;
						peak_q       <= '0;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign edges.valid           = out_valid_q;
	assign edges.edge_value      = out_edge_q;
	assign edges.edge_position   = out_pos_q;
	assign edges.last_of_run     = out_last_q;
	assign edges.peak_edge       = out_peak_edge_q;
	assign edges.peak_edge_index = out_peak_idx_q;
	assign edges.raw_peak        = out_raw_q;
	assign edges.auto_threshold  = out_thr_q;
	assign edges.tick_view_start = out_tick_q;
	assign edges.full_view_start = out_full_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_WINDOW))
		else $error("queue fill count above capacity");

	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we && ram_re |-> ram_waddr != ram_raddr)
		else $error("queue write and read hit the same entry");

	a_emit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SWEEP |-> e_q <= n_q)
		else $error("more entries to emit than pending");
`endif
endmodule
